[rtl/hlbe_pkg.sv]
`default_nettype none
package hlbe_pkg;

	localparam int LOSS_W = 11;
	localparam int RATIO_W = 11;
	localparam int RF_W = 10;
	localparam logic [RF_W-1:0] RF_RESET = 10'd256;
	localparam logic [LOSS_W-1:0] SMALL_LOSS = 11'd32;

	localparam int LOG_STEPS = 16;
	localparam int FRAC_W = 16;
	localparam int NORM_W = 31;

	localparam logic [18:0] DB_PER_OCT_Q16 = 19'd394566;
	localparam logic [21:0] OCT_PER_DB_K = 22'd2786635;
	localparam logic [17:0] FULL_SCALE_256 = 18'd25600;
	localparam logic [17:0] KNEE_256 = 18'd23040;
	localparam logic [14:0] RELIEF_RANGE_CAP = 15'd9600;
	localparam logic [15:0] RELIEF_CAP_Q16 = 16'd49152;
	localparam logic [19:0] RECIP_25 = 20'd671088;
	localparam logic [21:0] DIV_25 = 22'd25;
	localparam logic signed [20:0] MAX_LOSS_256 = 21'sd24320;

	localparam int GAIN_STEPS = 12;
	localparam int GAIN_W = 17;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;

	localparam int LATENCY = 44;

	typedef struct packed {
		logic valid;
		logic bypass;
	} hlbe_ctl_t;

	typedef struct packed {
		hlbe_ctl_t ctl;
		logic [LOSS_W-1:0] loss;
		logic [RATIO_W-1:0] ratio;
	} hlbe_tag_t;

	function automatic logic [15:0] pow2_neg(input logic [3:0] j);
		logic [15:0] v;
		case (j)
			4'd0: v = 16'd46341;
			4'd1: v = 16'd55109;
			4'd2: v = 16'd60097;
			4'd3: v = 16'd62757;
			4'd4: v = 16'd64132;
			4'd5: v = 16'd64830;
			4'd6: v = 16'd65182;
			4'd7: v = 16'd65359;
			4'd8: v = 16'd65447;
			4'd9: v = 16'd65492;
			4'd10: v = 16'd65514;
			4'd11: v = 16'd65525;
			default: v = 16'd65535;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[rtl/hlbe_log2.sv]
`default_nettype none
module hlbe_log2 #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire hlbe_pkg::hlbe_tag_t tag_in,
	input wire logic [SAMPLE_BITS-1:0] raw_in,
	output hlbe_pkg::hlbe_tag_t tag_out,
	output logic [SAMPLE_BITS-1:0] raw_out,
	output logic [$clog2(SAMPLE_BITS)-1:0] msb_out,
	output logic [hlbe_pkg::FRAC_W-1:0] frac_out
);

	localparam int PW = $clog2(SAMPLE_BITS);
	localparam int MW = hlbe_pkg::NORM_W;
	localparam int FW = hlbe_pkg::FRAC_W;
	localparam int NS = hlbe_pkg::LOG_STEPS;

	hlbe_pkg::hlbe_tag_t tag_s1;
	logic [SAMPLE_BITS-1:0] raw_s1;
	logic [SAMPLE_BITS-1:0] mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		raw_s1 <= raw_in;
		mag_s1 <= raw_in[SAMPLE_BITS-1] ? (~raw_in + 1'b1) : raw_in;
	end

	logic [PW-1:0] msb;
	logic [4:0] sh;

	always_comb begin
		msb = '0;
		for (int k = 0; k < SAMPLE_BITS; k++) begin
			if (mag_s1[k]) begin
				msb = PW'(k);
			end
		end
		sh = 5'(MW - 1) - 5'(msb);
	end

	hlbe_pkg::hlbe_tag_t tag_s [NS+1];
	logic [SAMPLE_BITS-1:0] raw_s [NS+1];
	logic [PW-1:0] msb_s [NS+1];
	logic [MW-1:0] m_s [NS+1];
	logic [FW-1:0] frac_s [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else begin
			tag_s[0] <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		raw_s[0] <= raw_s1;
		msb_s[0] <= msb;
		m_s[0] <= {{(MW-SAMPLE_BITS){1'b0}}, mag_s1} << sh;
		frac_s[0] <= '0;
	end

	for (genvar i = 0; i < NS; i++) begin : g_sq
		logic [2*MW-1:0] prod;
		logic [MW:0] sq;

		assign prod = (2*MW)'(m_s[i]) * (2*MW)'(m_s[i]);
		assign sq = prod[2*MW-1:MW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i+1] <= '0;
			end else begin
				tag_s[i+1] <= tag_s[i];
			end
		end

		always_ff @(posedge clk) begin
			raw_s[i+1] <= raw_s[i];
			msb_s[i+1] <= msb_s[i];
			m_s[i+1] <= sq[MW] ? sq[MW:1] : sq[MW-1:0];
			frac_s[i+1] <= {frac_s[i][FW-2:0], sq[MW]};
		end
	end

	assign tag_out = tag_s[NS];
	assign raw_out = raw_s[NS];
	assign msb_out = msb_s[NS];
	assign frac_out = frac_s[NS];

endmodule
`default_nettype wire

[rtl/hlbe_loss.sv]
`default_nettype none
module hlbe_loss #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire hlbe_pkg::hlbe_tag_t tag_in,
	input wire logic [SAMPLE_BITS-1:0] raw_in,
	input wire logic [$clog2(SAMPLE_BITS)-1:0] msb_in,
	input wire logic [hlbe_pkg::FRAC_W-1:0] frac_in,
	input wire logic [hlbe_pkg::RF_W-1:0] rf,
	output hlbe_pkg::hlbe_ctl_t ctl_out,
	output logic [SAMPLE_BITS-1:0] raw_out,
	output logic [14:0] eff_out
);

	localparam int PW = $clog2(SAMPLE_BITS);
	localparam int FW = hlbe_pkg::FRAC_W;
	localparam int DQW = PW + FW;
	localparam int DW = PW + 11;

	hlbe_pkg::hlbe_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8, tag_s9;
	logic [SAMPLE_BITS-1:0] raw_s1, raw_s2, raw_s3, raw_s4, raw_s5, raw_s6, raw_s7, raw_s8;
	logic [SAMPLE_BITS-1:0] raw_s9;

	logic [DQW-1:0] dq_s1;
	logic [DW-1:0] dn_s2;
	logic below_s3, below_s4, below_s5, below_s6, below_s7, below_s8;
	logic [15:0] diff_s3;
	logic [14:0] range_s3;
	logic cap_s4, cap_s5;
	logic [40:0] prod_s4;
	logic [20:0] x_s4, x_s5;
	logic [16:0] q0_s5;
	logic [21:0] t_s5;
	logic [19:0] effb_s5, effb_s6, effb_s7, effb_s8;
	logic [15:0] relief_s6;
	logic [30:0] rp_s7;
	logic [16:0] red_s8;
	logic [14:0] eff_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
			tag_s9 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
			tag_s9 <= tag_s8;
		end
	end

	logic [PW-1:0] oct;
	logic [DQW+18:0] dn_full;
	logic [17:0] sum;
	logic [20:0] ma;
	logic [19:0] mb;
	logic [21:0] r;
	logic [40:0] redp;
	logic signed [20:0] v;

	always_comb begin
		oct = PW'(SAMPLE_BITS - 1) - msb_in;
		dn_full = (DQW+19)'(dq_s1) * (DQW+19)'(hlbe_pkg::DB_PER_OCT_Q16);
		sum = 18'({tag_s2.loss, 4'b0}) + 18'(dn_s2);
		ma = below_s3 ? 21'(diff_s3) : {range_s3[13:0], 7'b0};
		mb = below_s3 ? 20'(tag_s3.ratio) : hlbe_pkg::RECIP_25;
		r = 22'(x_s5) - t_s5;
		redp = 41'(rp_s7) * 41'(rf);
		if (below_s8) begin
			v = signed'(21'(effb_s8));
		end else begin
			v = signed'(21'({tag_s8.loss, 4'b0}) - 21'(red_s8));
		end
	end

	always_ff @(posedge clk) begin
		raw_s1 <= raw_in;
		raw_s2 <= raw_s1;
		raw_s3 <= raw_s2;
		raw_s4 <= raw_s3;
		raw_s5 <= raw_s4;
		raw_s6 <= raw_s5;
		raw_s7 <= raw_s6;
		raw_s8 <= raw_s7;
		raw_s9 <= raw_s8;

		dq_s1 <= {oct, {FW{1'b0}}} - DQW'(frac_in);

		dn_s2 <= dn_full[DQW+18:24];

		below_s3 <= sum > hlbe_pkg::KNEE_256;
		diff_s3 <= 16'(sum - hlbe_pkg::KNEE_256);
		range_s3 <= 15'(hlbe_pkg::FULL_SCALE_256 - sum);

		below_s4 <= below_s3;
		cap_s4 <= range_s3 >= hlbe_pkg::RELIEF_RANGE_CAP;
		prod_s4 <= 41'(ma) * 41'(mb);
		x_s4 <= {range_s3[13:0], 7'b0};

		below_s5 <= below_s4;
		cap_s5 <= cap_s4;
		x_s5 <= x_s4;
		q0_s5 <= prod_s4[40:24];
		t_s5 <= 22'({prod_s4[40:24], 4'b0}) + 22'({prod_s4[40:24], 3'b0})
			+ 22'(prod_s4[40:24]);
		effb_s5 <= 20'({tag_s4.loss, 4'b0}) + 20'(prod_s4[26:8]);

		below_s6 <= below_s5;
		effb_s6 <= effb_s5;
		if (cap_s5) begin
			relief_s6 <= hlbe_pkg::RELIEF_CAP_Q16;
		end else if (r >= hlbe_pkg::DIV_25) begin
			relief_s6 <= 16'(q0_s5 + 17'd1);
		end else begin
			relief_s6 <= 16'(q0_s5);
		end

		below_s7 <= below_s6;
		effb_s7 <= effb_s6;
		rp_s7 <= 31'({tag_s6.loss, 4'b0}) * 31'(relief_s6);

		below_s8 <= below_s7;
		effb_s8 <= effb_s7;
		red_s8 <= redp[40:24];

		if (v < 21'sd0) begin
			eff_s9 <= '0;
		end else if (v > hlbe_pkg::MAX_LOSS_256) begin
			eff_s9 <= 15'(hlbe_pkg::MAX_LOSS_256);
		end else begin
			eff_s9 <= v[14:0];
		end
	end

	assign ctl_out = tag_s9.ctl;
	assign raw_out = raw_s9;
	assign eff_out = eff_s9;

endmodule
`default_nettype wire

[rtl/hlbe_gain.sv]
`default_nettype none
module hlbe_gain #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire hlbe_pkg::hlbe_ctl_t ctl_in,
	input wire logic [SAMPLE_BITS-1:0] raw_in,
	input wire logic [14:0] eff_in,
	output logic done,
	output logic [SAMPLE_BITS-1:0] out_sample
);

	localparam int GS = hlbe_pkg::GAIN_STEPS;
	localparam int GW = hlbe_pkg::GAIN_W;
	localparam int MPW = SAMPLE_BITS + GW;

	hlbe_pkg::hlbe_ctl_t ctl_s [GS+1];
	logic [SAMPLE_BITS-1:0] raw_s [GS+1];
	logic [4:0] n_s [GS+1];
	logic [GS-1:0] f_s [GS+1];
	logic [GW-1:0] g_s [GS+1];

	logic [36:0] ep;

	assign ep = 37'(eff_in) * 37'(hlbe_pkg::OCT_PER_DB_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		raw_s[0] <= raw_in;
		n_s[0] <= ep[36:32];
		f_s[0] <= ep[31:20];
		g_s[0] <= hlbe_pkg::UNITY_GAIN;
	end

	for (genvar i = 0; i < GS; i++) begin : g_step
		logic [GW+15:0] mult;

		assign mult = (GW+16)'(g_s[i]) * (GW+16)'(hlbe_pkg::pow2_neg(4'(i))) + (GW+16)'(32768);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			raw_s[i+1] <= raw_s[i];
			n_s[i+1] <= n_s[i];
			f_s[i+1] <= f_s[i];
			g_s[i+1] <= f_s[i][GS-1-i] ? mult[GW+15:16] : g_s[i];
		end
	end

	hlbe_pkg::hlbe_ctl_t ctl_s14, ctl_s15;
	logic [SAMPLE_BITS-1:0] raw_s14, raw_s15;
	logic [SAMPLE_BITS-1:0] mag_s14;
	logic [GW-1:0] gsh_s14;
	logic [SAMPLE_BITS-1:0] res_s15;
	logic done_q;
	logic [SAMPLE_BITS-1:0] out_q;
	logic [MPW-1:0] prod;

	assign prod = MPW'(mag_s14) * MPW'(gsh_s14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s14 <= '0;
			ctl_s15 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s14 <= ctl_s[GS];
			ctl_s15 <= ctl_s14;
			done_q <= ctl_s15.valid;
		end
	end

	always_ff @(posedge clk) begin
		raw_s14 <= raw_s[GS];
		gsh_s14 <= g_s[GS] >> n_s[GS];
		mag_s14 <= raw_s[GS][SAMPLE_BITS-1] ? (~raw_s[GS] + 1'b1) : raw_s[GS];

		raw_s15 <= raw_s14;
		res_s15 <= prod[SAMPLE_BITS+15:16];

		if (ctl_s15.bypass) begin
			out_q <= raw_s15;
		end else if (raw_s15[SAMPLE_BITS-1]) begin
			out_q <= ~res_s15 + 1'b1;
		end else begin
			out_q <= res_s15;
		end
	end

	assign done = done_q;
	assign out_sample = out_q;

endmodule
`default_nettype wire

[rtl/hearing_loss_band_expander_unit.sv]
// Fully pipelined hearing-loss band expander. A request is taken on every clock at which
// start is high; busy never rises, so one band sample per clock is sustained. The result
// shows on out_sample with done high for one clock, in request order; the receiver cannot
// stall it and must capture it in that cycle. The latency is set by the 16-step squaring
// chain of the level log2 and the 12-step product chain that turns the effective loss back
// into a gain, plus the level, threshold and recruitment stages between them. The user
// must write recruitment_factor through cfg_valid / cfg_ready (ready is always high) only
// while no request is in flight; the block itself does not enforce this.
`default_nettype none
module hearing_loss_band_expander_unit #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [SAMPLE_BITS-1:0] band_sample,
	input wire logic [hlbe_pkg::LOSS_W-1:0] loss_db,
	input wire logic [hlbe_pkg::RATIO_W-1:0] expansion_ratio,
	output logic done,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [hlbe_pkg::RF_W-1:0] recruitment_factor
);

	localparam int PW = $clog2(SAMPLE_BITS);

	logic accept;
	logic [hlbe_pkg::RF_W-1:0] rf_q;
	hlbe_pkg::hlbe_tag_t tag_s1;
	logic [SAMPLE_BITS-1:0] raw_s1;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q <= hlbe_pkg::RF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rf_q <= recruitment_factor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.ctl.valid <= accept;
			tag_s1.ctl.bypass <= (loss_db <= hlbe_pkg::SMALL_LOSS) || (band_sample == '0);
			tag_s1.loss <= loss_db;
			tag_s1.ratio <= expansion_ratio;
		end
	end

	always_ff @(posedge clk) begin
		raw_s1 <= band_sample;
	end

	hlbe_pkg::hlbe_tag_t lg_tag;
	logic [SAMPLE_BITS-1:0] lg_raw;
	logic [PW-1:0] lg_msb;
	logic [hlbe_pkg::FRAC_W-1:0] lg_frac;

	hlbe_log2 #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_log2 (
		.clk(clk),
		.arst_n(arst_n),
		.tag_in(tag_s1),
		.raw_in(raw_s1),
		.tag_out(lg_tag),
		.raw_out(lg_raw),
		.msb_out(lg_msb),
		.frac_out(lg_frac)
	);

	hlbe_pkg::hlbe_ctl_t ls_ctl;
	logic [SAMPLE_BITS-1:0] ls_raw;
	logic [14:0] ls_eff;

	hlbe_loss #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_loss (
		.clk(clk),
		.arst_n(arst_n),
		.tag_in(lg_tag),
		.raw_in(lg_raw),
		.msb_in(lg_msb),
		.frac_in(lg_frac),
		.rf(rf_q),
		.ctl_out(ls_ctl),
		.raw_out(ls_raw),
		.eff_out(ls_eff)
	);

	logic [SAMPLE_BITS-1:0] gn_out;

	hlbe_gain #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_gain (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(ls_ctl),
		.raw_in(ls_raw),
		.eff_in(ls_eff),
		.done(done),
		.out_sample(gn_out)
	);

	assign out_sample = signed'(gn_out);

endmodule
`default_nettype wire

[rtl/hlbe_checker.sv]
`default_nettype none
module hlbe_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [SAMPLE_BITS-1:0] band_sample,
	input wire logic [hlbe_pkg::LOSS_W-1:0] loss_db,
	input wire logic [SAMPLE_BITS-1:0] out_sample
);

	localparam int LAT = hlbe_pkg::LATENCY;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("request taken but no result after the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result strobe without a matching request");

	a_small_loss: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && loss_db <= hlbe_pkg::SMALL_LOSS
		|-> ##LAT out_sample == $past(band_sample, LAT))
		else $error("small loss request did not pass the sample through");

	a_zero_in: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && band_sample == '0 |-> ##LAT out_sample == '0)
		else $error("zero sample did not give zero");

endmodule

bind hearing_loss_band_expander_unit hlbe_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_hlbe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.band_sample(band_sample),
	.loss_db(loss_db),
	.out_sample(out_sample)
);
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int SAMPLE_BITS = 16;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam longint FULL_SCALE_256 = 25600;
	localparam longint MARGIN_256 = 2560;
	localparam longint MAX_LOSS_256 = 24320;
	localparam logic [63:0] DB_PER_OCT_Q16 = 64'd394566;
	localparam logic [63:0] OCT_PER_DB_K = 64'd2786635;
	localparam logic [63:0] RELIEF_CAP_Q16 = 64'd49152;
	localparam logic [63:0] FULL_SCALE_MAG = 64'd1 << SAMPLE_BITS;
	localparam logic [0:11][15:0] FRAC_STEP_GAIN = '{
		16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830,
		16'd65182, 16'd65359, 16'd65447, 16'd65492, 16'd65514, 16'd65525
	};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [SAMPLE_BITS-1:0] band_sample;
	logic [hlbe_pkg::LOSS_W-1:0] loss_db;
	logic [hlbe_pkg::RATIO_W-1:0] expansion_ratio;
	logic done;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic cfg_valid;
	logic cfg_ready;
	logic [hlbe_pkg::RF_W-1:0] recruitment_factor;

	logic [hlbe_pkg::RF_W-1:0] factor_now;
	logic [SAMPLE_BITS-1:0] attenuated_q[$];
	int errors = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;

	hearing_loss_band_expander_unit #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.band_sample(band_sample),
		.loss_db(loss_db),
		.expansion_ratio(expansion_ratio),
		.done(done),
		.out_sample(out_sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.recruitment_factor(recruitment_factor)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] magnitude_log2(input logic [63:0] a);
		int p;
		logic [63:0] m;
		logic [63:0] frac;
		p = 0;
		while (p < 63 && (a >> (p + 1)) != 0)
			p++;
		m = a << (30 - p);
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (64'(p) << 16) | frac;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] attenuate_sample(
		input logic [SAMPLE_BITS-1:0] raw,
		input logic [hlbe_pkg::LOSS_W-1:0] loss,
		input logic [hlbe_pkg::RATIO_W-1:0] ratio,
		input logic [hlbe_pkg::RF_W-1:0] factor
	);
		logic neg;
		logic [63:0] mag, down_q16, down256, diff, span, relief, red;
		logic [63:0] e, n, f, g, res;
		longint level, loss256, thr, eff;
		neg = raw[SAMPLE_BITS-1];
		mag = neg ? FULL_SCALE_MAG - 64'(raw) : 64'(raw);
		if (loss <= hlbe_pkg::SMALL_LOSS)
			return raw;
		if (mag == 0)
			return '0;
		down_q16 = (64'(SAMPLE_BITS - 1) << 16) - magnitude_log2(mag);
		down256 = (down_q16 * DB_PER_OCT_Q16) >> 24;
		level = FULL_SCALE_256 - longint'(down256);
		loss256 = longint'(loss) * 16;
		thr = loss256 + MARGIN_256;
		if (level < thr) begin
			diff = 64'(thr - level);
			eff = loss256 + longint'((diff * 64'(ratio)) >> 8);
		end else begin
			span = 64'(level - loss256);
			relief = (span * 256) / 50;
			if (relief > RELIEF_CAP_Q16)
				relief = RELIEF_CAP_Q16;
			red = (64'(loss256) * relief * 64'(factor)) >> 24;
			eff = loss256 - longint'(red);
		end
		if (eff < 0)
			eff = 0;
		if (eff > MAX_LOSS_256)
			eff = MAX_LOSS_256;
		e = (64'(eff) * OCT_PER_DB_K) >> 16;
		n = e >> 16;
		f = e & 64'hFFFF;
		g = 64'd65536;
		for (int j = 0; j < 12; j++) begin
			if (f[15-j])
				g = (g * 64'(FRAC_STEP_GAIN[j]) + 64'd32768) >> 16;
		end
		if (n > 16)
			n = 17;
		g = g >> n;
		res = (mag * g) >> 16;
		if (neg)
			res = -res;
		return res[SAMPLE_BITS-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk) begin
		logic [SAMPLE_BITS-1:0] want;
		if (arst_n && done) begin
			if (attenuated_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result out_sample=%0d", out_sample));
			end else begin
				want = attenuated_q.pop_front();
				if (out_sample !== want)
					report_mismatch($sformatf("out_sample got %0d want %0d",
						out_sample, $signed(want)));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(start && !busy) && !done && !(cfg_valid && cfg_ready))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_request(
		input logic [SAMPLE_BITS-1:0] s,
		input logic [hlbe_pkg::LOSS_W-1:0] loss,
		input logic [hlbe_pkg::RATIO_W-1:0] ratio
	);
		start <= 1'b1;
		band_sample <= s;
		loss_db <= loss;
		expansion_ratio <= ratio;
		do @(posedge clk); while (busy);
		attenuated_q.push_back(attenuate_sample(s, loss, ratio, factor_now));
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (attenuated_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_factor(input logic [hlbe_pkg::RF_W-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		recruitment_factor <= v;
		do @(posedge clk); while (!cfg_ready);
		factor_now = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_special_cases();
		idle_pct = 0;
		send_request(16'sd0, 11'd100, 11'd512);
		send_request(16'sd32767, 11'd32, 11'd256);
		send_request(-16'sd32768, 11'd0, 11'd0);
		send_request(-16'sd32768, 11'd33, 11'd256);
		send_request(16'sd32767, 11'd1440, 11'd2047);
		send_request(-16'sd32768, 11'd1440, 11'd256);
		send_request(16'sd32767, 11'd1439, 11'd300);
		send_request(16'sd1, 11'd1440, 11'd2047);
		send_request(-16'sd1, 11'd500, 11'd256);
		send_request(16'sd1, 11'd2047, 11'd0);
		send_request(16'sd32767, 11'd2047, 11'd255);
		send_request(16'sd16384, 11'd800, 11'd255);
		send_request(16'sd32767, 11'd33, 11'd2047);
		send_request(-16'sd20000, 11'd100, 11'd256);
		send_request(16'sd3000, 11'd300, 11'd512);
		send_request(16'sd0, 11'd0, 11'd2047);
		send_request(-16'sd2, 11'd33, 11'd1024);
		send_request(16'sd255, 11'd700, 11'd1000);
	endtask

	task automatic test_large_factor();
		write_factor(10'd1023);
		send_request(16'sd32767, 11'd33, 11'd256);
		send_request(-16'sd32768, 11'd600, 11'd256);
		send_request(16'sd20000, 11'd1200, 11'd256);
		send_request(-16'sd12345, 11'd300, 11'd2047);
		send_request(16'sd32767, 11'd2047, 11'd256);
		send_request(16'sd8000, 11'd64, 11'd256);
	endtask

	task automatic test_random_phase(input int count, input int pct);
		logic [SAMPLE_BITS-1:0] s;
		logic [hlbe_pkg::LOSS_W-1:0] loss;
		logic [hlbe_pkg::RATIO_W-1:0] ratio;
		int pick;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			s = SAMPLE_BITS'($urandom());
			if ($urandom_range(1))
				s = SAMPLE_BITS'($signed(s) >>> $urandom_range(SAMPLE_BITS - 1));
			pick = $urandom_range(99);
			if (pick < 8)
				loss = 11'($urandom_range(0, 32));
			else if (pick < 14)
				loss = 11'($urandom_range(1441, 2047));
			else
				loss = 11'($urandom_range(33, 1440));
			if ($urandom_range(99) < 10)
				ratio = 11'($urandom_range(0, 255));
			else
				ratio = 11'($urandom_range(256, 2047));
			send_request(s, loss, ratio);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		band_sample <= '0;
		loss_db <= '0;
		expansion_ratio <= '0;
		cfg_valid <= 1'b0;
		recruitment_factor <= hlbe_pkg::RF_RESET;
		factor_now = hlbe_pkg::RF_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_random_phase(80, 0);
		test_large_factor();
		test_random_phase(80, 0);
		write_factor(10'd0);
		test_random_phase(80, 56);
		write_factor(10'd512);
		test_random_phase(80, 23);
		write_factor(10'($urandom_range(1, 511)));
		test_random_phase(80, 56);

		drain_results();
		repeat (hlbe_pkg::LATENCY + 8) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
rtl/hlbe_pkg.sv
rtl/hlbe_log2.sv
rtl/hlbe_loss.sv
rtl/hlbe_gain.sv
rtl/hearing_loss_band_expander_unit.sv
rtl/hlbe_checker.sv
sim/tb.sv
